>>> rtl/tcsp_pkg.sv
// Shared types, telnet byte codes and reply tables for the telnet command parser.
// No dependencies; used by every module of the block.
`default_nettype none

package tcsp_pkg;

   // Default sizes
   localparam int CMD_DEPTH_DEF = 16;
   localparam int JOB_DEPTH_DEF = 4;

   // Telnet protocol bytes
   localparam logic [7:0] B_IAC  = 8'd255;
   localparam logic [7:0] B_DONT = 8'd254;
   localparam logic [7:0] B_DO   = 8'd253;
   localparam logic [7:0] B_WONT = 8'd252;
   localparam logic [7:0] B_WILL = 8'd251;
   localparam logic [7:0] B_SB   = 8'd250;
   localparam logic [7:0] B_SE   = 8'd240;
   localparam logic [7:0] B_SEND = 8'd1;
   localparam logic [7:0] B_IS   = 8'd0;

   // Options we agree to
   localparam logic [7:0] OPT_TTYPE   = 8'd24;
   localparam logic [7:0] OPT_TSPEED  = 8'd32;
   localparam logic [7:0] OPT_ENVIRON = 8'd39;

   // Channel codes
   localparam logic CH_DISPLAY = 1'b0;
   localparam logic CH_SERVER  = 1'b1;

   localparam int TEXT_LEN = 11;
   localparam int LEN_W    = 5;

   // "XTERM-COLOR"
   localparam logic [7:0] TTYPE_TEXT [TEXT_LEN] = '{
      8'h58, 8'h54, 8'h45, 8'h52, 8'h4d, 8'h2d, 8'h43, 8'h4f, 8'h4c, 8'h4f, 8'h52
   };
   // "38400,38400"
   localparam logic [7:0] SPEED_TEXT [TEXT_LEN] = '{
      8'h33, 8'h38, 8'h34, 8'h30, 8'h30, 8'h2c, 8'h33, 8'h38, 8'h34, 8'h30, 8'h30
   };

   // Work handed from the front end to the reply sequencer
   typedef enum logic [2:0] {
      JOB_PASS,
      JOB_LITERAL,
      JOB_WILL,
      JOB_WONT,
      JOB_SB_TTYPE,
      JOB_SB_TSPEED,
      JOB_SB_ENVIRON
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   data;
   } job_type;

   typedef struct packed {
      logic       channel;
      logic [7:0] value;
      logic       last;
   } rsp_type;

   // Number of result bytes a job expands to
   function automatic logic [LEN_W-1:0] job_len(input job_kind_type kind);
      logic [LEN_W-1:0] len;
      case (kind)
         JOB_PASS:       len = LEN_W'(1);
         JOB_LITERAL:    len = LEN_W'(1);
         JOB_WILL:       len = LEN_W'(3);
         JOB_WONT:       len = LEN_W'(3);
         JOB_SB_TTYPE:   len = LEN_W'(TEXT_LEN + 6);
         JOB_SB_TSPEED:  len = LEN_W'(TEXT_LEN + 6);
         JOB_SB_ENVIRON: len = LEN_W'(6);
         default:        len = LEN_W'(1);
      endcase
      return len;
   endfunction

   // Channel of every byte of a job
   function automatic logic job_channel(input job_kind_type kind);
      logic ch;
      case (kind)
         JOB_PASS:    ch = CH_DISPLAY;
         JOB_LITERAL: ch = CH_DISPLAY;
         default:     ch = CH_SERVER;
      endcase
      return ch;
   endfunction

   // Byte at position idx of a job
   function automatic logic [7:0] job_byte(input job_kind_type kind, input logic [7:0] data,
                                           input logic [LEN_W-1:0] idx);
      logic [7:0] b;
      logic [7:0] opt;
      logic [3:0] tidx;
      tidx = 4'(idx - LEN_W'(4));
      case (kind)
         JOB_SB_TTYPE:  opt = OPT_TTYPE;
         JOB_SB_TSPEED: opt = OPT_TSPEED;
         default:       opt = OPT_ENVIRON;
      endcase
      case (kind)
         JOB_PASS:    b = data;
         JOB_LITERAL: b = B_IAC;
         JOB_WILL, JOB_WONT: begin
            if (idx == LEN_W'(0)) begin
               b = B_IAC;
            end else if (idx == LEN_W'(1)) begin
               b = (kind == JOB_WILL) ? B_WILL : B_WONT;
            end else begin
               b = data;
            end
         end
         JOB_SB_TTYPE, JOB_SB_TSPEED, JOB_SB_ENVIRON: begin
            if (idx == LEN_W'(0)) begin
               b = B_IAC;
            end else if (idx == LEN_W'(1)) begin
               b = B_SB;
            end else if (idx == LEN_W'(2)) begin
               b = opt;
            end else if (idx == LEN_W'(3)) begin
               b = B_IS;
            end else if (idx == job_len(kind) - LEN_W'(2)) begin
               b = B_IAC;
            end else if (idx == job_len(kind) - LEN_W'(1)) begin
               b = B_SE;
            end else if (kind == JOB_SB_TTYPE) begin
               b = TTYPE_TEXT[tidx];
            end else begin
               b = SPEED_TEXT[tidx];
            end
         end
         default: b = data;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

>>> rtl/tcsp_front.sv
// Front end: gathers IAC commands byte by byte and classifies plain bytes and finished commands into jobs.
// Depends on tcsp_pkg.
`default_nettype none

module tcsp_front #(
   parameter int CMD_DEPTH = tcsp_pkg::CMD_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       rx_byte,
   output logic                  job_push,
   output tcsp_pkg::job_type     job_out
);
   import tcsp_pkg::*;

   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   // Command progress; only the store entries the parser ever reads are kept
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       code_ff, code_in;   // store[1]
   logic [7:0]       opt_ff, opt_in;     // store[2]
   logic [7:0]       arg_ff, arg_in;     // store[3]
   logic [7:0]       prev_ff, prev_in;   // last byte written
   logic [7:0]       tail_ff, tail_in;   // store[CMD_DEPTH-2]

   logic             appended;
   logic [CNT_W-1:0] cnt_new;
   logic [7:0]       before_byte;
   logic [7:0]       code_eff;

   assign appended    = count_ff < CNT_W'(CMD_DEPTH);
   assign cnt_new     = appended ? count_ff + CNT_W'(1) : count_ff;
   assign before_byte = appended ? prev_ff : tail_ff;
   assign code_eff    = (count_ff == CNT_W'(1)) ? rx_byte : code_ff;

   // Classify the incoming byte
   always_comb begin
      count_in     = count_ff;
      code_in      = code_ff;
      opt_in       = opt_ff;
      arg_in       = arg_ff;
      prev_in      = prev_ff;
      tail_in      = tail_ff;
      job_push     = 1'b0;
      job_out.kind = JOB_PASS;
      job_out.data = rx_byte;
      if (accept) begin
         if (count_ff == CNT_W'(0)) begin
            if (rx_byte == B_IAC) begin
               count_in = CNT_W'(1);
               prev_in  = rx_byte;
            end else begin
               job_push = 1'b1;
            end
         end else begin
            count_in = cnt_new;
            if (appended) begin
               prev_in = rx_byte;
               if (count_ff == CNT_W'(1)) code_in = rx_byte;
               if (count_ff == CNT_W'(2)) opt_in = rx_byte;
               if (count_ff == CNT_W'(3)) arg_in = rx_byte;
               if (count_ff == CNT_W'(CMD_DEPTH - 2)) tail_in = rx_byte;
            end
            case (code_eff)
               B_DO: begin
                  if (cnt_new == CNT_W'(3)) begin
                     job_push     = 1'b1;
                     job_out.kind = (rx_byte == OPT_TTYPE || rx_byte == OPT_TSPEED ||
                                     rx_byte == OPT_ENVIRON) ? JOB_WILL : JOB_WONT;
                     count_in     = CNT_W'(0);
                  end
               end
               B_DONT, B_WILL, B_WONT: begin
                  if (cnt_new == CNT_W'(3)) count_in = CNT_W'(0);
               end
               B_IAC: begin
                  job_push     = 1'b1;
                  job_out.kind = JOB_LITERAL;
                  count_in     = CNT_W'(0);
               end
               B_SB: begin
                  if (rx_byte == B_SE && before_byte == B_IAC) begin
                     count_in = CNT_W'(0);
                     // only a two-byte SEND body is answered
                     if (cnt_new == CNT_W'(6) && arg_ff == B_SEND) begin
                        if (opt_ff == OPT_TTYPE) begin
                           job_push     = 1'b1;
                           job_out.kind = JOB_SB_TTYPE;
                        end else if (opt_ff == OPT_TSPEED) begin
                           job_push     = 1'b1;
                           job_out.kind = JOB_SB_TSPEED;
                        end else if (opt_ff == OPT_ENVIRON) begin
                           job_push     = 1'b1;
                           job_out.kind = JOB_SB_ENVIRON;
                        end
                     end
                  end
               end
               default: count_in = CNT_W'(0);
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      code_ff <= code_in;
      opt_ff  <= opt_in;
      arg_ff  <= arg_in;
      prev_ff <= prev_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire

>>> rtl/tcsp_job_queue.sv
// Short queue of classified jobs between the front end and the reply sequencer.
// Depends on tcsp_pkg.
`default_nettype none

module tcsp_job_queue #(
   parameter int DEPTH = tcsp_pkg::JOB_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire tcsp_pkg::job_type push_job,
   output logic                   full,
   input  wire logic              pop,
   output logic                   valid,
   output tcsp_pkg::job_type      head_job
);
   import tcsp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full     = cnt_ff == CNT_W'(DEPTH);
   assign valid    = cnt_ff != CNT_W'(0);
   assign head_job = slot_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // Pointer and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

>>> rtl/tcsp_back.sv
// Reply sequencer: expands each job into result bytes, one per cycle while there is
// room, into a two-entry output buffer. Depends on tcsp_pkg.
`default_nettype none

module tcsp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   input  wire tcsp_pkg::job_type job,
   output logic                   job_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic                   rsp_out_channel,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_out_last
);
   import tcsp_pkg::*;

   logic [LEN_W-1:0] idx_ff, idx_in;
   rsp_type          buf_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             room;
   logic             emit;
   logic             is_last;
   logic             do_pop;
   rsp_type          next_rsp;

   assign room    = cnt_ff != 2'd2;
   assign emit    = job_valid && room;
   assign is_last = idx_ff == job_len(job.kind) - LEN_W'(1);
   assign job_pop = emit && is_last;
   assign do_pop  = rsp_pop && !rsp_empty;

   assign next_rsp.channel = job_channel(job.kind);
   assign next_rsp.value   = job_byte(job.kind, job.data, idx_ff);
   assign next_rsp.last    = is_last;

   assign rsp_empty       = cnt_ff == 2'd0;
   assign rsp_out_channel = buf_ff[rd_ff].channel;
   assign rsp_out_byte    = buf_ff[rd_ff].value;
   assign rsp_out_last    = buf_ff[rd_ff].last;

   // Byte position within the current job and buffer pointers
   always_comb begin
      idx_in = idx_ff;
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (emit) begin
         idx_in = is_last ? LEN_W'(0) : idx_ff + LEN_W'(1);
         wr_in  = !wr_ff;
      end
      if (do_pop) begin
         rd_in = !rd_ff;
      end
      if (emit && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !emit) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (emit) begin
         buf_ff[wr_ff] <= next_rsp;
      end
   end

endmodule

`default_nettype wire

>>> rtl/telnet_command_stream_parser.sv
// Telnet receive parser. One received byte is taken per cycle while the job queue
// has room (req_full low); plain bytes go via the job queue and output buffer to the
// display channel. IAC commands are gathered by the front end; a finished command is
// queued as a job and the reply sequencer plays it out at one result per cycle while
// its output buffer has room: 3 bytes for a DO reply, 6 for the environ reply and 17
// for the terminal-type or speed reply. Long reply bursts therefore fill the job
// queue and raise req_full; the sequencer's one-byte-per-cycle output sets the
// sustained rate. Depends on tcsp_pkg, tcsp_front, tcsp_job_queue and tcsp_back.
`default_nettype none

module telnet_command_stream_parser #(
   parameter int CMD_DEPTH = tcsp_pkg::CMD_DEPTH_DEF,
   parameter int JOB_DEPTH = tcsp_pkg::JOB_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic            rsp_out_channel,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last
);
   import tcsp_pkg::*;

   logic    accept;
   logic    front_push;
   job_type front_job;
   logic    queue_valid;
   job_type queue_job;
   logic    queue_pop;

   assign accept = req_push && !req_full;

   // Command gathering and classification
   tcsp_front #(
      .CMD_DEPTH (CMD_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .rx_byte  (req_rx_byte),
      .job_push (front_push),
      .job_out  (front_job)
   );

   // Decoupling queue
   tcsp_job_queue #(
      .DEPTH (JOB_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_job (front_job),
      .full     (req_full),
      .pop      (queue_pop),
      .valid    (queue_valid),
      .head_job (queue_job)
   );

   // Reply expansion and output buffer
   tcsp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (queue_valid),
      .job             (queue_job),
      .job_pop         (queue_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_channel (rsp_out_channel),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_last    (rsp_out_last)
   );

endmodule

`default_nettype wire

>>> tb/tb_telnet_command_stream_parser.sv
// Testbench for telnet_command_stream_parser: directed and random telnet byte streams,
// each result checked against a behavioural parser kept inside the bench.
// Depends on tcsp_pkg and the telnet_command_stream_parser RTL.

module tb_telnet_command_stream_parser;
   import tcsp_pkg::*;

   localparam int CMD_DEPTH = CMD_DEPTH_DEF;
   localparam logic [7:0] B_DATA_MARK = 8'd242;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 32;
   localparam int RANDOM_BYTES = 90;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [7:0] req_rx_byte = 8'd0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic rsp_out_channel;
   logic [7:0] rsp_out_byte;
   logic rsp_out_last;

   // Behavioural parser state
   logic [7:0] cmd_bytes [CMD_DEPTH];
   int unsigned cmd_len = 0;
   rsp_type reply_burst [$];
   rsp_type replies_due [$];

   logic [7:0] rx_run [$];
   int unsigned bytes_sent = 0;
   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;
   bit no_idle = 1'b0;
   bit hold_rsp_now = 1'b0;

   telnet_command_stream_parser #(
      .CMD_DEPTH(CMD_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_rx_byte(req_rx_byte),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_out_channel(rsp_out_channel),
      .rsp_out_byte(rsp_out_byte),
      .rsp_out_last(rsp_out_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic void add_reply(input logic channel, input logic [7:0] value);
      rsp_type r;
      r.channel = channel;
      r.value = value;
      r.last = 1'b0;
      reply_burst.push_back(r);
   endfunction

   function automatic void add_subneg_reply(input logic [7:0] opt, input string text);
      int i;
      add_reply(CH_SERVER, B_IAC);
      add_reply(CH_SERVER, B_SB);
      add_reply(CH_SERVER, opt);
      add_reply(CH_SERVER, B_IS);
      for (i = 0; i < text.len(); i++) begin
         add_reply(CH_SERVER, text[i]);
      end
      add_reply(CH_SERVER, B_IAC);
      add_reply(CH_SERVER, B_SE);
   endfunction

   function automatic bit in_subneg();
      return cmd_len >= 2 && cmd_bytes[1] == B_SB;
   endfunction

   // Work out the results caused by one accepted byte and queue them
   function automatic void parse_rx_byte(input logic [7:0] rx);
      bit agree;
      reply_burst.delete();
      if (cmd_len == 0) begin
         if (rx == B_IAC) begin
            cmd_bytes[0] = rx;
            cmd_len = 1;
         end else begin
            add_reply(CH_DISPLAY, rx);
         end
      end else begin
         // saturating store: bytes past the end are dropped
         if (cmd_len < CMD_DEPTH) begin
            cmd_bytes[cmd_len] = rx;
            cmd_len++;
         end
         case (cmd_bytes[1])
            B_DO: begin
               if (cmd_len == 3) begin
                  agree = (rx == OPT_TTYPE || rx == OPT_TSPEED || rx == OPT_ENVIRON);
                  add_reply(CH_SERVER, B_IAC);
                  add_reply(CH_SERVER, agree ? B_WILL : B_WONT);
                  add_reply(CH_SERVER, rx);
                  cmd_len = 0;
               end
            end
            B_DONT, B_WILL, B_WONT: begin
               if (cmd_len == 3) cmd_len = 0;
            end
            B_IAC: begin
               add_reply(CH_DISPLAY, B_IAC);
               cmd_len = 0;
            end
            B_SB: begin
               if (rx == B_SE && cmd_bytes[cmd_len - 2] == B_IAC) begin
                  // only a two-byte body ending in SEND is answered
                  if (cmd_len == 6 && cmd_bytes[3] == B_SEND) begin
                     case (cmd_bytes[2])
                        OPT_TTYPE:   add_subneg_reply(OPT_TTYPE, "XTERM-COLOR");
                        OPT_TSPEED:  add_subneg_reply(OPT_TSPEED, "38400,38400");
                        OPT_ENVIRON: add_subneg_reply(OPT_ENVIRON, "");
                        default: ;
                     endcase
                  end
                  cmd_len = 0;
               end
            end
            default: cmd_len = 0;
         endcase
      end
      if (reply_burst.size() > 0) reply_burst[reply_burst.size() - 1].last = 1'b1;
      foreach (reply_burst[i]) replies_due.push_back(reply_burst[i]);
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Each accepted result against the oldest expected one
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (replies_due.size() == 0) begin
            $error("result with none expected: out_channel %0d out_byte %0d out_last %0d",
                   rsp_out_channel, rsp_out_byte, rsp_out_last);
            mismatches++;
         end else begin
            want = replies_due.pop_front();
            check_field("out_channel", want.channel, rsp_out_channel);
            check_field("out_byte", want.value, rsp_out_byte);
            check_field("out_last", want.last, rsp_out_last);
         end
      end
   end

   // Watchdog: ends the run after too long with no request accepted and no result taken
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_telnet_command_stream_parser failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- driving

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Result side: random pop pattern, with a long hold-off on demand
   initial begin : response_sink
      int unsigned gap;
      int unsigned run;
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp_now) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp_now = 1'b0;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_pop <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            rsp_pop <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(negedge clock);
         end
      end
   end

   // One request: push stays high across back-to-back requests
   task automatic send_rx_byte(input logic [7:0] b);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      parse_rx_byte(b);
      bytes_sent++;
   endtask

   task automatic drain_replies();
      @(negedge clock);
      req_push <= 1'b0;
      while (replies_due.size() != 0) @(negedge clock);
   endtask

   // Close an open command; partial mode only closes long subnegotiations
   task automatic settle_command(input bit fully);
      while (cmd_len != 0 && (fully || (in_subneg() && cmd_len > 4))) begin
         if (in_subneg()) begin
            send_rx_byte(B_IAC);
            send_rx_byte(B_SE);
         end else begin
            send_rx_byte(8'($urandom_range(0, 239)));
         end
      end
   endtask

   // Subnegotiation that saturates the store; IAC lands in the entry the end test reads
   task automatic send_overlong_subneg(input int unsigned extra);
      settle_command(1'b1);
      send_rx_byte(B_IAC);
      send_rx_byte(B_SB);
      repeat (CMD_DEPTH - 4) send_rx_byte(8'($urandom_range(0, 254)));
      send_rx_byte(B_IAC);
      repeat (extra + 1) send_rx_byte(8'($urandom_range(0, 239)));
      send_rx_byte(B_SE);
   endtask

   function automatic logic [7:0] pick_option();
      case ($urandom_range(0, 5))
         0: return OPT_TTYPE;
         1: return OPT_TSPEED;
         2: return OPT_ENVIRON;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly well-formed commands with random content; some noise and cut-off ones
   task automatic send_random_run();
      int unsigned roll;
      int unsigned len;
      int unsigned keep;
      int unsigned i;
      settle_command($urandom_range(0, 9) < 7);
      rx_run.delete();
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         send_overlong_subneg($urandom_range(0, 3));
      end else begin
         if (roll < 30) begin
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++) rx_run.push_back(8'($urandom_range(0, 254)));
         end else if (roll < 36) begin
            rx_run.push_back(B_IAC);
            rx_run.push_back(B_IAC);
         end else if (roll < 50) begin
            rx_run.push_back(B_IAC);
            rx_run.push_back(B_DO);
            rx_run.push_back(pick_option());
         end else if (roll < 60) begin
            rx_run.push_back(B_IAC);
            case ($urandom_range(0, 2))
               0: rx_run.push_back(B_WILL);
               1: rx_run.push_back(B_WONT);
               default: rx_run.push_back(B_DONT);
            endcase
            rx_run.push_back(pick_option());
         end else if (roll < 78) begin
            rx_run.push_back(B_IAC);
            rx_run.push_back(B_SB);
            rx_run.push_back(pick_option());
            rx_run.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 254)) : B_SEND);
            rx_run.push_back(B_IAC);
            rx_run.push_back(B_SE);
         end else if (roll < 84) begin
            rx_run.push_back(B_IAC);
            rx_run.push_back(B_SB);
            len = $urandom_range(0, 4);
            for (i = 0; i < len; i++) rx_run.push_back(8'($urandom_range(0, 254)));
            rx_run.push_back(B_IAC);
            rx_run.push_back(B_SE);
         end else if (roll < 90) begin
            // data mark, SE and other unknown command bytes
            rx_run.push_back(B_IAC);
            rx_run.push_back(8'($urandom_range(0, 249)));
         end else begin
            len = $urandom_range(1, 3);
            for (i = 0; i < len; i++) rx_run.push_back(8'($urandom_range(0, 255)));
         end
         // cut some commands short
         if (rx_run.size() > 1 && $urandom_range(0, 9) == 0) begin
            keep = $urandom_range(1, rx_run.size() - 1);
            while (rx_run.size() > keep) void'(rx_run.pop_back());
         end
         foreach (rx_run[i]) send_rx_byte(rx_run[i]);
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_plain_and_literal();
      send_rx_byte(8'h00);
      send_rx_byte(8'hfe);
      send_rx_byte(B_IAC);
      send_rx_byte(B_IAC);
   endtask

   task automatic test_do_replies();
      send_rx_byte(B_IAC);
      send_rx_byte(B_DO);
      send_rx_byte(OPT_TTYPE);
      // refused option
      send_rx_byte(B_IAC);
      send_rx_byte(B_DO);
      send_rx_byte(8'h00);
   endtask

   task automatic test_silent_commands();
      send_rx_byte(B_IAC);
      send_rx_byte(B_WONT);
      send_rx_byte(OPT_ENVIRON);
      send_rx_byte(B_IAC);
      send_rx_byte(B_DATA_MARK);
   endtask

   task automatic test_subneg_replies();
      send_rx_byte(B_IAC);
      send_rx_byte(B_SB);
      send_rx_byte(OPT_TSPEED);
      send_rx_byte(B_SEND);
      send_rx_byte(B_IAC);
      send_rx_byte(B_SE);
      send_rx_byte(B_IAC);
      send_rx_byte(B_SB);
      send_rx_byte(OPT_ENVIRON);
      send_rx_byte(B_SEND);
      send_rx_byte(B_IAC);
      send_rx_byte(B_SE);
   endtask

   task automatic test_overlong_subneg();
      send_overlong_subneg(3);
      send_rx_byte(8'h41);
   endtask

   // Long replies while the result side holds off: input must stall on full
   task automatic test_reply_backpressure();
      int unsigned k;
      settle_command(1'b1);
      hold_rsp_now = 1'b1;
      no_idle = 1'b1;
      for (k = 0; k < 6; k++) begin
         send_rx_byte(B_IAC);
         send_rx_byte(B_SB);
         send_rx_byte((k % 2 == 0) ? OPT_TTYPE : OPT_TSPEED);
         send_rx_byte(B_SEND);
         send_rx_byte(B_IAC);
         send_rx_byte(B_SE);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_drain_pause();
      drain_replies();
      send_rx_byte(B_IAC);
      send_rx_byte(B_DO);
      send_rx_byte(OPT_ENVIRON);
      send_rx_byte(8'h7f);
   endtask

   task automatic test_random_stream();
      int unsigned start;
      start = bytes_sent;
      // first stretch runs with no idling on either side
      no_idle = 1'b1;
      while (bytes_sent < start + RANDOM_BYTES) begin
         if (bytes_sent > start + 40) no_idle = 1'b0;
         send_random_run();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_plain_and_literal();
      test_do_replies();
      test_silent_commands();
      test_subneg_replies();
      test_overlong_subneg();
      test_reply_backpressure();
      test_drain_pause();
      test_random_stream();

      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && replies_due.size() == 0) begin
         $display("tb_telnet_command_stream_parser passed");
      end else begin
         $display("tb_telnet_command_stream_parser failed");
      end
      $finish;
   end

endmodule
